// ===== rtl/fxa_pkg.sv =====
// Shared types and opcodes for the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none

package fxa_pkg;

  localparam int FIELD_WIDTH = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_GT  = 4'd4,
    OP_LT  = 4'd5,
    OP_LE  = 4'd6,
    OP_GE  = 4'd7,
    OP_EQ  = 4'd8,
    OP_NE  = 4'd9,
    OP_INC = 4'd10,
    OP_DEC = 4'd11
  } op_t;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } operands_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               compare_true;
    logic               divide_by_zero;
  } result_t;

  // Per-word control that rides along the cell row.
  typedef struct packed {
    logic [3:0] op;
    logic       neg;
    logic       cmp;
    logic       dz;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/fxa_prep.sv =====
// Input stage: operand wrap, magnitudes, simple ops and cell row setup.
`timescale 1ns / 1ps
`default_nettype none

module fxa_prep #(
  parameter int RAW_WIDTH = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fxa_pkg::operands_t         word,
  input  logic                       word_valid,
  output logic                       word_ready,
  input  logic                       dn_ready,
  output logic                       valid,
  output fxa_pkg::ctrl_t             ctrl,
  output logic [RAW_WIDTH+FRAC_BITS-1:0] bits,
  output logic [2*RAW_WIDTH-1:0]     acc,
  output logic [RAW_WIDTH-1:0]       q,
  output logic [RAW_WIDTH-1:0]       m
);
  import fxa_pkg::*;

  localparam int W  = RAW_WIDTH;
  localparam int N  = RAW_WIDTH + FRAC_BITS;

  logic signed [W-1:0] a_w;
  logic signed [W-1:0] b_w;
  logic                neg_a;
  logic                neg_b;
  logic [W-1:0]        mag_a;
  logic [W-1:0]        mag_b;
  ctrl_t               ctrl_next;
  logic [N-1:0]        bits_next;
  logic [W-1:0]        q_next;
  logic [W-1:0]        m_next;

  assign word_ready = !valid || dn_ready;

  always_comb begin
    a_w   = W'($signed(word.operand_a));
    b_w   = W'($signed(word.operand_b));
    neg_a = a_w[W-1];
    neg_b = b_w[W-1];
    mag_a = neg_a ? W'(-a_w) : W'(a_w);
    mag_b = neg_b ? W'(-b_w) : W'(b_w);

    ctrl_next.op  = word.op;
    ctrl_next.neg = neg_a ^ neg_b;
    ctrl_next.cmp = 1'b0;
    ctrl_next.dz  = (word.op == OP_DIV) && (b_w == '0);
    bits_next     = '0;
    q_next        = '0;
    m_next        = '0;

    unique case (word.op)
      OP_ADD: q_next = W'(a_w + b_w);
      OP_SUB: q_next = W'(a_w - b_w);
      OP_INC: q_next = W'(a_w + W'(1));
      OP_DEC: q_next = W'(a_w - W'(1));
      OP_MUL: begin
        // multiplier bits feed the row MSB first; leading zeros keep the sum at zero
        bits_next = N'(mag_b);
        m_next    = mag_a;
      end
      OP_DIV: begin
        bits_next = N'(mag_a) << FRAC_BITS;
        m_next    = mag_b;
      end
      OP_GT:  ctrl_next.cmp = a_w > b_w;
      OP_LT:  ctrl_next.cmp = a_w < b_w;
      OP_LE:  ctrl_next.cmp = a_w <= b_w;
      OP_GE:  ctrl_next.cmp = a_w >= b_w;
      OP_EQ:  ctrl_next.cmp = a_w == b_w;
      OP_NE:  ctrl_next.cmp = a_w != b_w;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (word_ready) begin
      valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_ready && word_valid) begin
      ctrl <= ctrl_next;
      bits <= bits_next;
      acc  <= '0;
      q    <= q_next;
      m    <= m_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fxa_cell.sv =====
// One cell of the row: a multiply shift-add step or a restoring divide step.
`timescale 1ns / 1ps
`default_nettype none

module fxa_cell #(
  parameter int RAW_WIDTH = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  input  fxa_pkg::ctrl_t                 up_ctrl,
  input  logic [RAW_WIDTH+FRAC_BITS-1:0] up_bits,
  input  logic [2*RAW_WIDTH-1:0]         up_acc,
  input  logic [RAW_WIDTH-1:0]           up_q,
  input  logic [RAW_WIDTH-1:0]           up_m,
  output logic                           up_ready,
  input  logic                           dn_ready,
  output logic                           valid,
  output fxa_pkg::ctrl_t                 ctrl,
  output logic [RAW_WIDTH+FRAC_BITS-1:0] bits,
  output logic [2*RAW_WIDTH-1:0]         acc,
  output logic [RAW_WIDTH-1:0]           q,
  output logic [RAW_WIDTH-1:0]           m
);
  import fxa_pkg::*;

  localparam int W  = RAW_WIDTH;
  localparam int N  = RAW_WIDTH + FRAC_BITS;
  localparam int AW = 2 * RAW_WIDTH;

  logic          bit_in;
  logic [W:0]    trial;
  logic [N-1:0]  bits_next;
  logic [AW-1:0] acc_next;
  logic [W-1:0]  q_next;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    bit_in    = up_bits[N-1];
    bits_next = up_bits << 1;
    acc_next  = up_acc;
    q_next    = up_q;
    trial     = {up_acc[W-1:0], bit_in};

    unique case (up_ctrl.op)
      OP_MUL: begin
        acc_next = {up_acc[AW-2:0], 1'b0} + (bit_in ? AW'(up_m) : AW'(0));
      end
      OP_DIV: begin
        // remainder lives in the low bits of acc
        if (trial >= {1'b0, up_m}) begin
          acc_next = AW'(trial - {1'b0, up_m});
          q_next   = {up_q[W-2:0], 1'b1};
        end else begin
          acc_next = AW'(trial);
          q_next   = {up_q[W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctrl <= up_ctrl;
      bits <= bits_next;
      acc  <= acc_next;
      q    <= q_next;
      m    <= up_m;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fxa_post.sv =====
// Output stage: sign fix-up, product scaling, result select and output register.
`timescale 1ns / 1ps
`default_nettype none

module fxa_post #(
  parameter int RAW_WIDTH = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  input  fxa_pkg::ctrl_t         up_ctrl,
  input  logic [2*RAW_WIDTH-1:0] up_acc,
  input  logic [RAW_WIDTH-1:0]   up_q,
  output logic                   up_ready,
  output logic                   valid,
  input  logic                   stall,
  output fxa_pkg::result_t       word
);
  import fxa_pkg::*;

  localparam int W  = RAW_WIDTH;
  localparam int AW = 2 * RAW_WIDTH;
  localparam int PW = AW + FRAC_BITS;

  logic [AW-1:0]        sprod;
  logic signed [PW-1:0] pext;
  logic signed [PW-1:0] pshift;
  logic [W-1:0]         v_w;
  result_t              word_next;

  assign up_ready = !valid || !stall;

  always_comb begin
    sprod  = up_ctrl.neg ? (AW'(0) - up_acc) : up_acc;
    pext   = PW'($signed(sprod));
    pshift = pext >>> FRAC_BITS;

    unique case (up_ctrl.op)
      OP_MUL: v_w = pshift[W-1:0];
      OP_DIV: begin
        if (up_ctrl.dz) begin
          v_w = '0;
        end else begin
          v_w = up_ctrl.neg ? (W'(0) - up_q) : up_q;
        end
      end
      default: v_w = up_q;
    endcase

    word_next.value          = FIELD_WIDTH'($signed(v_w));
    word_next.compare_true   = up_ctrl.cmp;
    word_next.divide_by_zero = up_ctrl.dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fixed_point_alu_q24_8_core.sv =====
// Top level of the signed fixed-point ALU: input stage, cell row, output stage.
//
//   channel    direction  handshake                      word
//   operands   into       operands_valid/operands_stall  op, operand_a, operand_b
//   result     out of     result_valid/result_stall      value, compare_true, divide_by_zero
//
// One word enters per cycle while operands_stall is low; each passes through the input
// stage, the cell row and the output stage, one multiply or divide step per cell.
// Reset clears every stage's valid bit; data registers keep whatever
// they hold. A stall on the result side reaches back through every full stage in
// the same cycle while empty stages still fill, so operands_stall rises only once
// every stage holds a word.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu_q24_8_core #(
  parameter int RAW_WIDTH = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               operands_valid,
  output logic               operands_stall,
  input  fxa_pkg::operands_t operands,
  output logic               result_valid,
  input  logic               result_stall,
  output fxa_pkg::result_t   result
);
  import fxa_pkg::*;

  localparam int W  = RAW_WIDTH;
  localparam int N  = RAW_WIDTH + FRAC_BITS;
  localparam int AW = 2 * RAW_WIDTH;

  logic          st_valid [0:N];
  ctrl_t         st_ctrl  [0:N];
  logic [N-1:0]  st_bits  [0:N];
  logic [AW-1:0] st_acc   [0:N];
  logic [W-1:0]  st_q     [0:N];
  logic [W-1:0]  st_m     [0:N];
  logic          ready    [0:N+1];

  assign operands_stall = !ready[0];

  fxa_prep #(
    .RAW_WIDTH(RAW_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .word       (operands),
    .word_valid (operands_valid),
    .word_ready (ready[0]),
    .dn_ready   (ready[1]),
    .valid      (st_valid[0]),
    .ctrl       (st_ctrl[0]),
    .bits       (st_bits[0]),
    .acc        (st_acc[0]),
    .q          (st_q[0]),
    .m          (st_m[0])
  );

  for (genvar k = 1; k <= N; k++) begin : g_cell
    fxa_cell #(
      .RAW_WIDTH(RAW_WIDTH),
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (st_valid[k-1]),
      .up_ctrl  (st_ctrl[k-1]),
      .up_bits  (st_bits[k-1]),
      .up_acc   (st_acc[k-1]),
      .up_q     (st_q[k-1]),
      .up_m     (st_m[k-1]),
      .up_ready (ready[k]),
      .dn_ready (ready[k+1]),
      .valid    (st_valid[k]),
      .ctrl     (st_ctrl[k]),
      .bits     (st_bits[k]),
      .acc      (st_acc[k]),
      .q        (st_q[k]),
      .m        (st_m[k])
    );
  end

  fxa_post #(
    .RAW_WIDTH(RAW_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .up_valid (st_valid[N]),
    .up_ctrl  (st_ctrl[N]),
    .up_acc   (st_acc[N]),
    .up_q     (st_q[N]),
    .up_ready (ready[N+1]),
    .valid    (result_valid),
    .stall    (result_stall),
    .word     (result)
  );

endmodule

`default_nettype wire

// ===== rtl/fxa_checker.sv =====
// Port-level checks for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fxa_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input fxa_pkg::result_t result
);

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.compare_true && result.divide_by_zero))
    else $error("compare and divide-by-zero flags both set");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.divide_by_zero |-> result.value == '0)
    else $error("divide by zero with nonzero value");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.compare_true |-> result.value == '0)
    else $error("comparison word with nonzero value");

endmodule

bind fixed_point_alu_q24_8_core fxa_checker u_fxa_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
